/* sv/ivr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivr_pkg
// Shared types and fixed field widths for the inverse variance rebinner.
// ----------------------------------------------------------------------------
package ivr_pkg;

    // fixed field widths
    localparam int WAVE_W       = 24;
    localparam int FLUCT_W      = 24;
    localparam int WEIGHT_W     = 24;
    localparam int OUT_WEIGHT_W = 30;
    localparam int GROUP_W      = 7;

    // quotient width and iteration counter of the bit-serial divider
    localparam int QUOT_W = 24;
    localparam int ITER_W = 5;

    // largest reportable bin weight
    localparam logic [OUT_WEIGHT_W-1:0] WEIGHT_OUT_MAX = 30'h3FFF_FFFF;

    // one spectrum pixel
    typedef struct packed {
        logic        [WAVE_W-1:0]   in_wavelength;
        logic signed [FLUCT_W-1:0]  in_fluctuation;
        logic        [WEIGHT_W-1:0] in_weight;
        logic                       in_last;
    } pixel_t;

    // one output bin
    typedef struct packed {
        logic        [WAVE_W-1:0]       out_wavelength;
        logic signed [FLUCT_W-1:0]      out_fluctuation;
        logic        [OUT_WEIGHT_W-1:0] out_weight;
        logic                           out_last;
    } bin_t;

endpackage

/* sv/inverse_variance_rebinner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_variance_rebinner
// Merges runs of spectrum pixels into inverse-variance weighted bins.
// ----------------------------------------------------------------------------
//   channel   direction  handshake               payload
//   cfg       in         cfg_valid / cfg_ready   cfg_data   (group_size)
//   pixel     in         pixel_valid / stall     pixel_t
//   bin       out        bin_valid / bin_stall   bin_t
//
// In the front a pixel is captured, multiplied and accumulated.
// A closed bin then passes through the two 24-step bit-serial dividers in
// the back, which run in parallel.
// A two-entry queue lets the front keep taking pixels while the back divides.
// Reset is asynchronous, active low; sums clear and group_size reads 1.
// The output register holds a bin while bin_stall is high.
// ----------------------------------------------------------------------------
module inverse_variance_rebinner
    import ivr_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [GROUP_W-1:0] cfg_data,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  pixel_t             pixel,
    output logic               bin_valid,
    input  logic               bin_stall,
    output bin_t               bin
);

    localparam int LG          = $clog2(MAX_GROUP);
    localparam int CNT_W       = $clog2(MAX_GROUP + 1);
    localparam int WW_SUM_W    = 2 * WAVE_W + LG;
    localparam int F_SUM_W     = FLUCT_W + WEIGHT_W + LG;
    localparam int W_SUM_W     = WEIGHT_W + LG;
    localparam int P_SUM_W     = WAVE_W + LG;
    localparam int REC_W       = WW_SUM_W + F_SUM_W + W_SUM_W + P_SUM_W + CNT_W + 1;
    localparam int QUEUE_DEPTH = 2;

    logic                      push;
    logic                      full;
    logic                      pop;
    logic                      empty;
    logic [WW_SUM_W-1:0]       f_ww_sum;
    logic signed [F_SUM_W-1:0] f_f_sum;
    logic [W_SUM_W-1:0]        f_w_sum;
    logic [P_SUM_W-1:0]        f_p_sum;
    logic [CNT_W-1:0]          f_count;
    logic                      f_last;
    logic [WW_SUM_W-1:0]       q_ww_sum;
    logic signed [F_SUM_W-1:0] q_f_sum;
    logic [W_SUM_W-1:0]        q_w_sum;
    logic [P_SUM_W-1:0]        q_p_sum;
    logic [CNT_W-1:0]          q_count;
    logic                      q_last;
    logic [REC_W-1:0]          wr_rec;
    logic [REC_W-1:0]          rd_rec;

    // accumulation front
    ivr_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .push        (push),
        .full        (full),
        .bin_ww_sum  (f_ww_sum),
        .bin_f_sum   (f_f_sum),
        .bin_w_sum   (f_w_sum),
        .bin_p_sum   (f_p_sum),
        .bin_count   (f_count),
        .bin_last    (f_last)
    );

    // bin record packing
    assign wr_rec = {f_ww_sum, f_f_sum, f_w_sum, f_p_sum, f_count, f_last};
    assign {q_ww_sum, q_f_sum, q_w_sum, q_p_sum, q_count, q_last} = rd_rec;

    // queue of closed bins
    ivr_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_rec),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_rec),
        .empty   (empty)
    );

    // division back end
    ivr_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .q_ww_sum  (q_ww_sum),
        .q_f_sum   (q_f_sum),
        .q_w_sum   (q_w_sum),
        .q_p_sum   (q_p_sum),
        .q_count   (q_count),
        .q_last    (q_last),
        .bin_valid (bin_valid),
        .bin_stall (bin_stall),
        .bin       (bin)
    );

endmodule

/* sv/ivr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivr_queue
// Small register queue holding finished bin sums between front and back.
// ----------------------------------------------------------------------------
module ivr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // no overflow, no underflow
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

/* sv/ivr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivr_front
// Takes pixels, forms the weighted products and accumulates the bin sums;
// a closed bin goes into the queue.
// ----------------------------------------------------------------------------
module ivr_front
    import ivr_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [GROUP_W-1:0]                       cfg_data,
    input  logic                                     pixel_valid,
    output logic                                     pixel_stall,
    input  pixel_t                                   pixel,
    output logic                                     push,
    input  logic                                     full,
    output logic [2*WAVE_W+$clog2(MAX_GROUP)-1:0]    bin_ww_sum,
    output logic signed [FLUCT_W+WEIGHT_W+$clog2(MAX_GROUP)-1:0] bin_f_sum,
    output logic [WEIGHT_W+$clog2(MAX_GROUP)-1:0]    bin_w_sum,
    output logic [WAVE_W+$clog2(MAX_GROUP)-1:0]      bin_p_sum,
    output logic [$clog2(MAX_GROUP+1)-1:0]           bin_count,
    output logic                                     bin_last
);

    localparam int LG       = $clog2(MAX_GROUP);
    localparam int CNT_W    = $clog2(MAX_GROUP + 1);
    localparam int PROD_W   = 2 * WAVE_W;
    localparam int WW_SUM_W = PROD_W + LG;
    localparam int F_SUM_W  = FLUCT_W + WEIGHT_W + LG;
    localparam int W_SUM_W  = WEIGHT_W + LG;
    localparam int P_SUM_W  = WAVE_W + LG;
    localparam int CMP_W    = (CNT_W > GROUP_W) ? CNT_W : GROUP_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_ACC  = 3'b100
    } front_state_t;

    front_state_t              state_reg, state_next;
    logic [GROUP_W-1:0]        group_size_reg;
    pixel_t                    pix_reg;
    logic [PROD_W-1:0]         wprod_reg;
    logic signed [PROD_W-1:0]  fprod_reg;
    logic [WW_SUM_W-1:0]       ww_sum_reg;
    logic signed [F_SUM_W-1:0] f_sum_reg;
    logic [W_SUM_W-1:0]        w_sum_reg;
    logic [P_SUM_W-1:0]        p_sum_reg;
    logic [CNT_W-1:0]          count_reg;

    logic [PROD_W-1:0]         wprod;
    logic signed [PROD_W-1:0]  fprod;
    logic [WW_SUM_W-1:0]       ww_add;
    logic signed [F_SUM_W-1:0] f_add;
    logic [W_SUM_W-1:0]        w_add;
    logic [P_SUM_W-1:0]        p_add;
    logic [CNT_W-1:0]          cnt_add;
    logic [CMP_W-1:0]          gs_x;
    logic [CMP_W-1:0]          eff_group;
    logic                      close;
    logic                      accept;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = (state_reg != F_IDLE);
    assign accept      = pixel_valid && !pixel_stall;

    // products of the held pixel
    assign wprod = pix_reg.in_wavelength * pix_reg.in_weight;
    assign fprod = pix_reg.in_fluctuation * $signed({1'b0, pix_reg.in_weight});

    // running sums with the current pixel added
    assign ww_add  = ww_sum_reg + WW_SUM_W'(wprod_reg);
    assign f_add   = f_sum_reg + F_SUM_W'(fprod_reg);
    assign w_add   = w_sum_reg + W_SUM_W'(pix_reg.in_weight);
    assign p_add   = p_sum_reg + P_SUM_W'(pix_reg.in_wavelength);
    assign cnt_add = count_reg + 1'b1;

    // group size clamped into 1..MAX_GROUP
    assign gs_x = CMP_W'(group_size_reg);
    always_comb
    begin
        if (gs_x == '0)
        begin
            eff_group = CMP_W'(1);
        end
        else if (gs_x > CMP_W'(MAX_GROUP))
        begin
            eff_group = CMP_W'(MAX_GROUP);
        end
        else
        begin
            eff_group = gs_x;
        end
    end

    assign close = pix_reg.in_last || (CMP_W'(cnt_add) >= eff_group);
    assign push  = (state_reg == F_ACC) && close && !full;

    assign bin_ww_sum = ww_add;
    assign bin_f_sum  = f_add;
    assign bin_w_sum  = w_add;
    assign bin_p_sum  = p_add;
    assign bin_count  = cnt_add;
    assign bin_last   = pix_reg.in_last;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_ACC;
            end
            F_ACC:
            begin
                if (!close || !full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control state, group size register and bin sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            group_size_reg <= GROUP_W'(1);
            ww_sum_reg     <= '0;
            f_sum_reg      <= '0;
            w_sum_reg      <= '0;
            p_sum_reg      <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                group_size_reg <= cfg_data;
            end
            if (state_reg == F_ACC)
            begin
                if (!close)
                begin
                    ww_sum_reg <= ww_add;
                    f_sum_reg  <= f_add;
                    w_sum_reg  <= w_add;
                    p_sum_reg  <= p_add;
                    count_reg  <= cnt_add;
                end
                else if (!full)
                begin
                    ww_sum_reg <= '0;
                    f_sum_reg  <= '0;
                    w_sum_reg  <= '0;
                    p_sum_reg  <= '0;
                    count_reg  <= '0;
                end
            end
        end
    end

    // pixel capture and product registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixel;
        end
        if (state_reg == F_MUL)
        begin
            wprod_reg <= wprod;
            fprod_reg <= fprod;
        end
    end

endmodule

/* sv/ivr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivr_div
// Bit-serial restoring divider with round-half-up; one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ivr_div
    import ivr_pkg::*;
#(
    parameter int NUM_W = 56,
    parameter int DEN_W = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic [QUOT_W-1:0] quot
);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              ge;

    assign busy = (iter_reg != '0);
    assign quot = q_reg;
    assign ge   = (rem_reg >= dsh_reg);

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (start)
        begin
            iter_reg <= ITER_W'(QUOT_W);
        end
        else if (busy)
        begin
            iter_reg <= iter_reg - 1'b1;
        end
    end

    // remainder, shifted divisor and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num + NUM_W'(den >> 1);
            dsh_reg <= NUM_W'(den) << (QUOT_W - 1);
            q_reg   <= '0;
        end
        else if (busy)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QUOT_W-2:0], ge};
        end
    end

endmodule

/* sv/ivr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivr_back
// Takes closed bins from the queue, runs the two mean divisions in parallel
// and holds the finished bin in the output register.
// ----------------------------------------------------------------------------
module ivr_back
    import ivr_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     empty,
    output logic                                     pop,
    input  logic [2*WAVE_W+$clog2(MAX_GROUP)-1:0]    q_ww_sum,
    input  logic signed [FLUCT_W+WEIGHT_W+$clog2(MAX_GROUP)-1:0] q_f_sum,
    input  logic [WEIGHT_W+$clog2(MAX_GROUP)-1:0]    q_w_sum,
    input  logic [WAVE_W+$clog2(MAX_GROUP)-1:0]      q_p_sum,
    input  logic [$clog2(MAX_GROUP+1)-1:0]           q_count,
    input  logic                                     q_last,
    output logic                                     bin_valid,
    input  logic                                     bin_stall,
    output bin_t                                     bin
);

    localparam int LG       = $clog2(MAX_GROUP);
    localparam int F_SUM_W  = FLUCT_W + WEIGHT_W + LG;
    localparam int W_SUM_W  = WEIGHT_W + LG;
    localparam int NUM_W    = 2 * WAVE_W + LG + 1;
    localparam int DEN_W    = W_SUM_W;
    localparam int OW_CMP_W = (DEN_W > OUT_WEIGHT_W) ? DEN_W : OUT_WEIGHT_W;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 zero_reg;
    logic                 neg_reg;
    logic                 last_reg;
    logic [W_SUM_W-1:0]   wsum_reg;
    logic                 bin_valid_reg;
    bin_t                 bin_reg;

    logic                 zero_w;
    logic [F_SUM_W-1:0]   fmag;
    logic [NUM_W-1:0]     num_a;
    logic [NUM_W-1:0]     num_b;
    logic [DEN_W-1:0]     den;
    logic                 busy_a;
    logic                 busy_b;
    logic [QUOT_W-1:0]    quot_a;
    logic [QUOT_W-1:0]    quot_b;
    logic                 load;
    logic [OW_CMP_W-1:0]  wsum_x;
    bin_t                 bin_new;

    // operand selection at pop
    assign zero_w = (q_w_sum == '0);
    assign fmag   = q_f_sum[F_SUM_W-1] ? F_SUM_W'(-q_f_sum) : F_SUM_W'(q_f_sum);
    assign num_a  = zero_w ? NUM_W'(q_p_sum) : NUM_W'(q_ww_sum);
    assign num_b  = NUM_W'(fmag);
    assign den    = zero_w ? DEN_W'(q_count) : q_w_sum;

    assign pop  = (state_reg == B_IDLE) && !empty;
    assign load = (state_reg == B_DONE) && (!bin_valid_reg || !bin_stall);

    // wavelength (or plain) mean
    ivr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_wave (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop),
        .num   (num_a),
        .den   (den),
        .busy  (busy_a),
        .quot  (quot_a)
    );

    // fluctuation magnitude mean
    ivr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_fluct (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop),
        .num   (num_b),
        .den   (den),
        .busy  (busy_b),
        .quot  (quot_b)
    );

    // finished bin
    assign wsum_x = OW_CMP_W'(wsum_reg);
    always_comb
    begin
        bin_new.out_wavelength = quot_a;
        if (zero_reg)
        begin
            bin_new.out_fluctuation = '0;
        end
        else if (neg_reg)
        begin
            bin_new.out_fluctuation = $signed(FLUCT_W'(-quot_b));
        end
        else
        begin
            bin_new.out_fluctuation = $signed(quot_b);
        end
        if (wsum_x > OW_CMP_W'(WEIGHT_OUT_MAX))
        begin
            bin_new.out_weight = WEIGHT_OUT_MAX;
        end
        else
        begin
            bin_new.out_weight = wsum_x[OUT_WEIGHT_W-1:0];
        end
        bin_new.out_last = last_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (!busy_a)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            bin_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                bin_valid_reg <= 1'b1;
            end
            else if (!bin_stall)
            begin
                bin_valid_reg <= 1'b0;
            end
        end
    end

    // bin attributes and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            zero_reg <= zero_w;
            neg_reg  <= q_f_sum[F_SUM_W-1];
            last_reg <= q_last;
            wsum_reg <= q_w_sum;
        end
        if (load)
        begin
            bin_reg <= bin_new;
        end
    end

    assign bin_valid = bin_valid_reg;
    assign bin       = bin_reg;

    // unweighted bin never reports a fluctuation
    a_zero_weight_fluct: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid_reg |-> (bin_reg.out_weight != '0 || bin_reg.out_fluctuation == '0))
        else $error("zero-weight bin with nonzero fluctuation");

    // both dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        busy_a == busy_b)
        else $error("dividers out of step");

    // result is loaded only once the division has finished
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_a)
        else $error("bin loaded while division running");

endmodule

/* tb/sv/inverse_variance_rebinner_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_variance_rebinner_test
// Self-checking bench for the pixel rebinner. A driver feeds pixels and
// group size writes from a command queue, an in-bench bin calculator predicts
// each closed bin, and a monitor compares every bin against the oldest
// prediction while both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module inverse_variance_rebinner_test;
    import ivr_pkg::*;

    localparam int MAX_GROUP    = 64;
    localparam int SETTLE_TICKS = 40;       // quiet cycles before a group size write
    localparam int TAIL_TICKS   = 60;
    localparam int QUIET_ITEMS  = 120;      // last items run without idling
    localparam int RANDOM_ITEMS = 1300;
    localparam longint LIMIT_NS = 64'd5_000_000;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_CONFIG,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct {
        cmd_kind_t          kind;
        pixel_t             pix;
        logic [GROUP_W-1:0] group;
    } feed_cmd_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [GROUP_W-1:0] cfg_data;
    logic               pixel_valid;
    logic               pixel_stall;
    pixel_t             pixel;
    logic               bin_valid;
    logic               bin_stall;
    bin_t               bin;

    feed_cmd_t   pixel_feed[$];
    bin_t        bins_due[$];
    int unsigned errors;

    // bin calculator state
    logic [GROUP_W-1:0] group_size;
    int unsigned        acc_count;
    logic [63:0]        acc_wave;
    logic signed [63:0] acc_fluct;
    logic [63:0]        acc_weight;
    logic [63:0]        acc_plain;

    // pacing state
    int unsigned gap_left;
    int unsigned settle_count;
    int unsigned stall_left;
    int unsigned tick;
    bit          idle_on;
    bit          stall_on;
    logic        quiet;

    inverse_variance_rebinner #(
        .MAX_GROUP(MAX_GROUP)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel      (pixel),
        .bin_valid  (bin_valid),
        .bin_stall  (bin_stall),
        .bin        (bin)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    // add one pixel to the accumulator, returns 1 and the bin when it closes
    function automatic bit rebin_pixel(input pixel_t p, output bin_t b);
        logic [63:0]        wave;
        logic [63:0]        wgt;
        logic signed [63:0] fl;
        logic [63:0]        neg_sum;
        logic [63:0]        mag;
        logic [63:0]        wave_mean;
        logic [63:0]        fl_mean;
        int unsigned        limit;
        wave = {40'd0, p.in_wavelength};
        wgt  = {40'd0, p.in_weight};
        fl   = {{40{p.in_fluctuation[FLUCT_W-1]}}, p.in_fluctuation};
        acc_wave   += wave * wgt;
        acc_fluct  += fl * $signed(wgt);
        acc_weight += wgt;
        acc_plain  += wave;
        acc_count++;
        b = '0;
        // zero group acts as one, oversize groups saturate
        if (group_size == 0)
            limit = 1;
        else if (group_size > MAX_GROUP)
            limit = MAX_GROUP;
        else
            limit = group_size;
        if (!p.in_last && acc_count < limit)
            return 1'b0;
        if (acc_weight == 0)
        begin
            // masked bin: plain mean, no fluctuation
            wave_mean = (acc_plain + 64'(acc_count) / 2) / 64'(acc_count);
            fl_mean   = '0;
        end
        else
        begin
            wave_mean = (acc_wave + acc_weight / 2) / acc_weight;
            // signed mean rounds half away from zero
            if (acc_fluct < 0)
            begin
                neg_sum = -acc_fluct;
                mag     = (neg_sum + acc_weight / 2) / acc_weight;
                fl_mean = -mag;
            end
            else
            begin
                neg_sum = acc_fluct;
                fl_mean = (neg_sum + acc_weight / 2) / acc_weight;
            end
        end
        b.out_wavelength  = wave_mean[WAVE_W-1:0];
        b.out_fluctuation = fl_mean[FLUCT_W-1:0];
        b.out_weight      = (acc_weight > 64'(WEIGHT_OUT_MAX)) ? WEIGHT_OUT_MAX
                                                               : acc_weight[OUT_WEIGHT_W-1:0];
        b.out_last        = p.in_last;
        acc_count  = 0;
        acc_wave   = '0;
        acc_fluct  = '0;
        acc_weight = '0;
        acc_plain  = '0;
        return 1'b1;
    endfunction

    task automatic add_pixel(input logic [23:0] wave, input logic [23:0] fluct,
                             input logic [23:0] weight, input logic last);
        feed_cmd_t c;
        c.kind               = CMD_PIXEL;
        c.pix.in_wavelength  = wave;
        c.pix.in_fluctuation = fluct;
        c.pix.in_weight      = weight;
        c.pix.in_last        = last;
        c.group              = '0;
        pixel_feed.insert(pixel_feed.size(), c);
    endtask

    // wait for an idle block, then write the group size
    task automatic add_group_write(input logic [GROUP_W-1:0] g);
        feed_cmd_t c;
        c.kind  = CMD_DRAIN;
        c.pix   = '0;
        c.group = '0;
        pixel_feed.insert(pixel_feed.size(), c);
        c.kind  = CMD_CONFIG;
        c.group = g;
        pixel_feed.insert(pixel_feed.size(), c);
    endtask

    // pixel and config driver, predicts at acceptance
    always @(posedge clk or negedge rst_n)
    begin : feed_driver
        bin_t predicted;
        logic pv_next;
        logic cv_next;
        if (!rst_n)
        begin
            pixel_valid  <= 1'b0;
            pixel        <= '0;
            cfg_valid    <= 1'b0;
            cfg_data     <= '0;
            quiet        <= 1'b0;
            gap_left     = 0;
            settle_count = 0;
            idle_on      = 1'b1;
            group_size   = 7'd1;
            acc_count    = 0;
            acc_wave     = '0;
            acc_fluct    = '0;
            acc_weight   = '0;
            acc_plain    = '0;
        end
        else
        begin
            pv_next = pixel_valid;
            cv_next = cfg_valid;
            if (pixel_valid && !pixel_stall)
            begin
                if (rebin_pixel(pixel, predicted))
                    bins_due.insert(bins_due.size(), predicted);
                pv_next = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                group_size = cfg_data;
                cv_next    = 1'b0;
                idle_on    = ($urandom_range(0, 2) != 0);
            end
            // next command once the channels are free
            if (!pv_next && !cv_next && pixel_feed.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    case (pixel_feed[0].kind)
                        CMD_PIXEL:
                        begin
                            if (!quiet && idle_on && $urandom_range(0, 3) == 0)
                                gap_left = $urandom_range(1, 14) - 1;
                            else
                            begin
                                pixel   <= pixel_feed[0].pix;
                                pv_next = 1'b1;
                                void'(pixel_feed.pop_front());
                            end
                        end
                        CMD_CONFIG:
                        begin
                            cfg_data <= pixel_feed[0].group;
                            cv_next  = 1'b1;
                            void'(pixel_feed.pop_front());
                        end
                        default:
                        begin
                            // hold off until every bin is back and the front settles
                            if (bins_due.size() == 0)
                            begin
                                settle_count++;
                                if (settle_count >= SETTLE_TICKS)
                                begin
                                    settle_count = 0;
                                    void'(pixel_feed.pop_front());
                                end
                            end
                            else
                                settle_count = 0;
                        end
                    endcase
                end
            end
            pixel_valid <= pv_next;
            cfg_valid   <= cv_next;
            quiet       <= (pixel_feed.size() < QUIET_ITEMS);
        end
    end

    // bin monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin : bin_monitor
        bin_t want;
        if (!rst_n)
        begin
            bin_stall  <= 1'b0;
            stall_left = 0;
            stall_on   = 1'b1;
            tick       = 0;
        end
        else
        begin
            if (bin_valid && !bin_stall)
            begin
                if (bins_due.size() == 0)
                    report_mismatch("bin with none expected, wavelength",
                                    64'(bin.out_wavelength), '0);
                else
                begin
                    want = bins_due.pop_front();
                    if (bin.out_wavelength !== want.out_wavelength)
                        report_mismatch("out_wavelength", 64'(bin.out_wavelength),
                                        64'(want.out_wavelength));
                    if (bin.out_fluctuation !== want.out_fluctuation)
                        report_mismatch("out_fluctuation", 64'(bin.out_fluctuation),
                                        64'(want.out_fluctuation));
                    if (bin.out_weight !== want.out_weight)
                        report_mismatch("out_weight", 64'(bin.out_weight),
                                        64'(want.out_weight));
                    if (bin.out_last !== want.out_last)
                        report_mismatch("out_last", 64'(bin.out_last), 64'(want.out_last));
                end
            end
            // stretches with and without stalls
            tick++;
            if (tick % 256 == 0)
                stall_on = ($urandom_range(0, 2) != 0);
            if (stall_left > 0)
            begin
                stall_left--;
                bin_stall <= 1'b1;
            end
            else if (!quiet && stall_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                bin_stall  <= 1'b1;
            end
            else
                bin_stall <= 1'b0;
        end
    end

    // timeout
    initial
    begin
        #(LIMIT_NS);
        $display("** inverse_variance_rebinner: FAILED **");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int unsigned total;
        int unsigned count;
        int unsigned eff;
        int unsigned zero_pct;
        int unsigned pick;
        logic [GROUP_W-1:0] g;
        logic [23:0] wave;
        logic [23:0] fluct;
        logic [23:0] weight;
        logic        last;
        rst_n       = 1'b0;

        // directed: reset group size of one, field extremes
        add_pixel(24'h000000, 24'h000000, 24'h000000, 1'b0);
        add_pixel(24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b0);
        add_pixel(24'hFFFFFF, 24'h800000, 24'hFFFFFF, 1'b1);
        add_pixel(24'h123456, 24'hFFFFFF, 24'h000001, 1'b0);
        // pairs: rounding halves and masked bins
        add_group_write(7'd2);
        add_pixel(24'd100, 24'hFFFFFF, 24'd1, 1'b0);
        add_pixel(24'd101, 24'h000000, 24'd1, 1'b0);
        add_pixel(24'd0, 24'h000001, 24'd1, 1'b0);
        add_pixel(24'd0, 24'h000000, 24'd1, 1'b0);
        add_pixel(24'd5, 24'h000123, 24'd0, 1'b0);
        add_pixel(24'd6, 24'h800000, 24'd0, 1'b0);
        // short group flushed by the last pixel
        add_pixel(24'hABCDEF, 24'h654321, 24'h000777, 1'b1);
        // zero group acts as one
        add_group_write(7'd0);
        add_pixel(24'h000010, 24'h7FFFFF, 24'h000000, 1'b0);
        add_pixel(24'h000011, 24'h800001, 24'h000002, 1'b0);
        // group lowered while a bin is half full
        add_group_write(7'd8);
        for (int i = 0; i < 5; i++)
            add_pixel(24'(i * 1000 + 7), 24'(-i), 24'(i + 1), 1'b0);
        add_group_write(7'd3);
        add_pixel(24'h00FFFF, 24'h000004, 24'h000003, 1'b0);
        add_pixel(24'h00FFF0, 24'h000005, 24'h000000, 1'b1);

        // full largest group at maximum weight
        add_group_write(7'd127);
        for (int i = 0; i < MAX_GROUP; i++)
            add_pixel(24'hFFFFFF, (i % 2 == 0) ? 24'h7FFFFF : 24'h800000, 24'hFFFFFF, 1'b0);

        // random phases
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1:    g = 7'd1;
                2, 3:    g = 7'd2;
                4, 5:    g = 7'd3;
                6:       g = 7'd4;
                7:       g = 7'd5;
                8:       g = 7'd8;
                9:       g = 7'd16;
                10:      g = 7'd0;
                11:      g = (total % 2 == 0) ? 7'd64 : 7'd127;
                12:      g = 7'(65 + $urandom_range(0, 62));
                default: g = 7'($urandom_range(1, 12));
            endcase
            add_group_write(g);
            eff      = (g == 0) ? 1 : (g > MAX_GROUP) ? MAX_GROUP : g;
            zero_pct = ($urandom_range(0, 4) == 0) ? 70 : 10;
            count    = (eff > 16) ? $urandom_range(60, 140) : $urandom_range(30, 100);
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       wave = 24'h000000;
                    1:       wave = 24'hFFFFFF;
                    default: wave = 24'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       fluct = 24'h800000;
                    1:       fluct = 24'h7FFFFF;
                    2:       fluct = 24'($signed($urandom_range(0, 8)) - 4);
                    default: fluct = 24'($urandom);
                endcase
                if ($urandom_range(0, 99) < zero_pct)
                    weight = 24'h000000;
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       weight = 24'hFFFFFF;
                        1:       weight = 24'($urandom_range(1, 3));
                        default: weight = 24'($urandom);
                    endcase
                end
                last = ($urandom_range(0, eff + eff / 2 + 2) == 0);
                add_pixel(wave, fluct, weight, last);
            end
            total += count;
        end
        // flush whatever is still open
        add_pixel(24'h400000, 24'h000100, 24'h000100, 1'b1);

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the feed, the bins and a settling tail
        while (pixel_feed.size() != 0 || pixel_valid || cfg_valid)
            @(posedge clk);
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_TICKS) @(posedge clk);
        if (errors == 0)
            $display("** inverse_variance_rebinner: PASSED **");
        else
            $display("** inverse_variance_rebinner: FAILED **");
        $finish;
    end

endmodule
